// ----- sv/ast_pkg.sv -----
package ast_pkg;

    // Widest token length the design supports (MAX_TOKEN upper bound)
    localparam int LEN_W = 9;

    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [15:0] LINE_ONE = 16'd1;

    localparam logic [1:0] CLS_WORD   = 2'd0;
    localparam logic [1:0] CLS_STRING = 2'd1;
    localparam logic [1:0] CLS_SYMBOL = 2'd2;
    localparam logic [1:0] CLS_END    = 2'd3;

    typedef enum logic [1:0] {
        M_IDLE,
        M_WORD,
        M_STR,
        M_ESC
    } t_mode;

    typedef enum logic {
        B_IDLE,
        B_SHOW
    } t_bstate;

    // One token to emit; use_store selects bytes from the token store bank
    typedef struct packed {
        logic             use_store;
        logic             bank;
        logic [7:0]       sym;
        logic [1:0]       cls;
        logic [15:0]      line;
        logic [LEN_W-1:0] len;
        logic             trunc;
        logic             unterm;
        logic             run_last;
    } t_cmd;

    typedef struct packed {
        logic v0;
        logic v1;
        t_cmd c0;
        t_cmd c1;
    } t_push;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c == CH_UNDER) || (c inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

endpackage

// ----- sv/ast_front.sv -----
module ast_front #(
    parameter int MAX_TOKEN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_end_of_input,
    input  logic                          i_room2,
    output ast_pkg::t_push                o_push,
    input  ast_pkg::t_release             i_release,
    output logic                          o_we,
    output logic [$clog2(MAX_TOKEN):0]    o_waddr,
    output logic [7:0]                    o_wdata
);
    import ast_pkg::*;

    localparam int IW = $clog2(MAX_TOKEN);
    localparam int CW = $clog2(MAX_TOKEN + 1);

    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_line, n_line;
    logic [15:0]   r_start, n_start;
    logic          r_ovf, n_ovf;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;

    logic          accept;
    logic          need_bank;
    logic          do_idle;
    logic          ibank;
    logic          fa, fb;
    t_cmd          cmd_a, cmd_b;
    logic [1:0]    set_mask, rel_mask;

    assign need_bank = (r_mode == M_WORD) ? ~r_bank : r_bank;
    assign o_ready   = i_room2 && !r_busy[need_bank];
    assign accept    = i_valid && o_ready;
    assign o_wdata   = i_in_byte;

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_line   = r_line;
        n_start  = r_start;
        n_ovf    = r_ovf;
        n_bank   = r_bank;
        set_mask = 2'b00;
        fa       = 1'b0;
        fb       = 1'b0;
        cmd_a    = '0;
        cmd_b    = '0;
        o_we     = 1'b0;
        o_waddr  = {r_bank, r_count[IW-1:0]};
        do_idle  = 1'b0;
        ibank    = r_bank;

        // Pending token description, used whenever it gets flushed
        cmd_a.use_store = 1'b1;
        cmd_a.bank      = r_bank;
        cmd_a.line      = r_start;
        cmd_a.len       = LEN_W'(r_count);
        cmd_a.trunc     = r_ovf;
        cmd_a.cls       = CLS_WORD;

        if (accept) begin
            if (i_end_of_input) begin
                case (r_mode)
                    M_WORD: begin
                        fa = 1'b1;
                    end
                    M_STR, M_ESC: begin
                        fa           = 1'b1;
                        cmd_a.cls    = CLS_STRING;
                        cmd_a.unterm = 1'b1;
                    end
                    default: ;
                endcase
                fb           = 1'b1;
                cmd_b.cls    = CLS_END;
                cmd_b.line   = r_line;
                n_mode       = M_IDLE;
                n_count      = '0;
                n_line       = LINE_ONE;
                n_start      = LINE_ONE;
                n_ovf        = 1'b0;
                if (fa) begin
                    n_bank           = ~r_bank;
                    set_mask[r_bank] = 1'b1;
                end
            end else begin
                case (r_mode)
                    M_WORD: begin
                        if (is_word(i_in_byte)) begin
                            if (32'(r_count) < MAX_TOKEN) begin
                                o_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            fa               = 1'b1;
                            n_count          = '0;
                            n_ovf            = 1'b0;
                            n_mode           = M_IDLE;
                            n_bank           = ~r_bank;
                            set_mask[r_bank] = 1'b1;
                            do_idle          = 1'b1;
                            ibank            = ~r_bank;
                        end
                    end
                    M_STR: begin
                        if (i_in_byte == CH_QUOTE) begin
                            fa               = 1'b1;
                            cmd_a.cls        = CLS_STRING;
                            n_count          = '0;
                            n_ovf            = 1'b0;
                            n_mode           = M_IDLE;
                            n_bank           = ~r_bank;
                            set_mask[r_bank] = 1'b1;
                        end else if (i_in_byte == CH_BSLASH) begin
                            n_mode = M_ESC;
                        end else if (32'(r_count) < MAX_TOKEN) begin
                            o_we    = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    M_ESC: begin
                        n_mode = M_STR;
                        if (32'(r_count) < MAX_TOKEN) begin
                            o_we    = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_idle) begin
                    if (is_space(i_in_byte)) begin
                        if (i_in_byte == CH_NL && r_line != LINE_MAX) begin
                            n_line = r_line + 16'd1;
                        end
                    end else if (is_word(i_in_byte)) begin
                        o_we    = 1'b1;
                        o_waddr = {ibank, {IW{1'b0}}};
                        n_count = CW'(1);
                        n_ovf   = 1'b0;
                        n_start = r_line;
                        n_mode  = M_WORD;
                    end else if (i_in_byte == CH_QUOTE) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_start = r_line;
                        n_mode  = M_STR;
                    end else begin
                        fb         = 1'b1;
                        cmd_b.cls  = CLS_SYMBOL;
                        cmd_b.line = r_line;
                        cmd_b.len  = LEN_W'(1);
                        cmd_b.sym  = i_in_byte;
                    end
                end
            end
        end

        // Mark the last token of this item
        if (fb) begin
            cmd_b.run_last = 1'b1;
        end else begin
            cmd_a.run_last = 1'b1;
        end

        o_push.v0 = fa || fb;
        o_push.v1 = fa && fb;
        o_push.c0 = fa ? cmd_a : cmd_b;
        o_push.c1 = cmd_b;

        rel_mask = 2'b00;
        if (i_release.valid) begin
            rel_mask[i_release.bank] = 1'b1;
        end
        n_busy = (r_busy & ~rel_mask) | set_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_count <= '0;
            r_line  <= LINE_ONE;
            r_start <= LINE_ONE;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_line  <= n_line;
            r_start <= n_start;
            r_ovf   <= n_ovf;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

endmodule

// ----- sv/ast_cmdq.sv -----
module ast_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ast_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_nonempty,
    output logic           o_room2,
    output ast_pkg::t_cmd  o_head
);
    import ast_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] wptr1;
    logic [1:0] npush;

    assign o_nonempty = (r_cnt != 3'd0);
    assign o_room2    = (r_cnt <= 3'd2);
    assign o_head     = r_mem[r_rptr];

    always_comb begin
        npush  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
        wptr1  = r_wptr + 2'(i_push.v0);
        n_wptr = r_wptr + npush;
        n_rptr = r_rptr + 2'(i_pop);
        n_cnt  = r_cnt + 3'(npush) - 3'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.c0;
        end
        if (i_push.v1) begin
            r_mem[wptr1] <= i_push.c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- sv/ast_back.sv -----
module ast_back #(
    parameter int MAX_TOKEN = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [$clog2(MAX_TOKEN):0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_nonempty,
    input  ast_pkg::t_cmd              i_head,
    output logic                       o_pop,
    output ast_pkg::t_release          o_release,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_token_byte,
    output logic [1:0]                 o_token_class,
    output logic [15:0]                o_token_line,
    output logic [4:0]                 o_byte_index,
    output logic [5:0]                 o_token_length,
    output logic                       o_token_last,
    output logic                       o_run_last,
    output logic                       o_truncated,
    output logic                       o_unterminated
);
    import ast_pkg::*;

    localparam int IW = $clog2(MAX_TOKEN);

    // Two banks of MAX_TOKEN bytes
    logic [7:0]    r_store [2**(IW+1)];
    logic [7:0]    r_rdata;

    t_bstate       r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_idx, n_idx;
    logic          rd_en;
    logic [IW:0]   rd_addr;
    logic          last;
    logic [31:0]   idx32;
    logic [31:0]   len32;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    assign idx32 = 32'(r_idx);
    assign len32 = 32'(r_cmd.len);
    assign last  = (len32 == 32'd0) || (idx32 + 32'd1 == len32);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        rd_en     = 1'b0;
        rd_addr   = {r_cmd.bank, r_idx + 1'b1};
        o_pop     = 1'b0;
        o_release = '0;
        o_valid   = 1'b0;
        case (r_state)
            B_IDLE: begin
                rd_addr = {i_head.bank, {IW{1'b0}}};
                if (i_nonempty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_idx   = '0;
                    rd_en   = i_head.use_store;
                    n_state = B_SHOW;
                end
            end
            B_SHOW: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (last) begin
                        o_release.valid = r_cmd.use_store;
                        o_release.bank  = r_cmd.bank;
                        n_state         = B_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        rd_en = 1'b1;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
    end

    always_comb begin
        if (!r_cmd.use_store) begin
            o_token_byte = r_cmd.sym;
        end else if (len32 == 32'd0) begin
            o_token_byte = 8'h00;
        end else begin
            o_token_byte = r_rdata;
        end
    end

    assign o_token_class  = r_cmd.cls;
    assign o_token_line   = r_cmd.line;
    assign o_byte_index   = idx32[4:0];
    assign o_token_length = len32[5:0];
    assign o_token_last   = last;
    assign o_run_last     = last && r_cmd.run_last;
    assign o_truncated    = r_cmd.trunc;
    assign o_unterminated = r_cmd.unterm;

endmodule

// ----- sv/assembler_source_tokenizer.sv -----
// Channel | Direction | Handshake         | Payload
// input   | in        | i_valid / o_ready | i_in_byte, i_end_of_input
// output  | out       | o_valid / i_ready | o_token_* , o_byte_index, o_run_last, flags
//
// The scanner takes one byte per cycle while the command queue has two free slots
// and the store bank it would fill is not still being read out.
// The emitter loads each token from the queue, then shows its bytes one at a time, each held until taken.
// Reset is synchronous, active low; it clears control state only, not the store.
// A stall at the output backs up into the queue, then the input.
module assembler_source_tokenizer #(
    parameter int MAX_TOKEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_token_byte,
    output logic [1:0]  o_token_class,
    output logic [15:0] o_token_line,
    output logic [4:0]  o_byte_index,
    output logic [5:0]  o_token_length,
    output logic        o_token_last,
    output logic        o_run_last,
    output logic        o_truncated,
    output logic        o_unterminated
);
    import ast_pkg::*;

    localparam int IW = $clog2(MAX_TOKEN);

    t_push       push;
    t_release    release_b;
    t_cmd        head;
    logic        room2;
    logic        nonempty;
    logic        pop;
    logic        we;
    logic [IW:0] waddr;
    logic [7:0]  wdata;

    // Front: classify bytes, fill the token store, queue finished tokens
    ast_front #(
        .MAX_TOKEN(MAX_TOKEN)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_room2        (room2),
        .o_push         (push),
        .i_release      (release_b),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata)
    );

    // Short queue of token commands between the two halves
    ast_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_room2    (room2),
        .o_head     (head)
    );

    // Back: hold the token store and stream each token out byte by byte
    ast_back #(
        .MAX_TOKEN(MAX_TOKEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (we),
        .i_waddr        (waddr),
        .i_wdata        (wdata),
        .i_nonempty     (nonempty),
        .i_head         (head),
        .o_pop          (pop),
        .o_release      (release_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_byte   (o_token_byte),
        .o_token_class  (o_token_class),
        .o_token_line   (o_token_line),
        .o_byte_index   (o_byte_index),
        .o_token_length (o_token_length),
        .o_token_last   (o_token_last),
        .o_run_last     (o_run_last),
        .o_truncated    (o_truncated),
        .o_unterminated (o_unterminated)
    );

endmodule

// ----- sv/ast_checker.sv -----
module ast_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_token_byte,
    input logic [1:0]  o_token_class,
    input logic [15:0] o_token_line,
    input logic [4:0]  o_byte_index,
    input logic [5:0]  o_token_length,
    input logic        o_token_last,
    input logic        o_run_last
);
    import ast_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_byte) && $stable(o_token_class)
            && $stable(o_token_line) && $stable(o_byte_index))
        else $error("output item changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_last |-> o_token_last)
        else $error("run end not on token end");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_class == CLS_END |-> o_token_last && o_run_last
            && o_token_length == 6'd0 && o_token_byte == 8'h00)
        else $error("malformed end token");

    a_empty_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_length == 6'd0 |-> o_byte_index == 5'd0 && o_token_last)
        else $error("empty token not a single item");

endmodule

bind assembler_source_tokenizer ast_checker u_ast_checker (.*);
